// ===== rtl/deadline_timer_table_top_macros.svh =====
// assertion macros shared by the timer table rtl
`ifndef DEADLINE_TIMER_TABLE_TOP_MACROS_SVH
`define DEADLINE_TIMER_TABLE_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define DTT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define DTT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/dtt_pkg.sv =====
// shared constants, codes and types of the timer table
`default_nettype none
package dtt_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_BITS   = 4;
   localparam int TIME_BITS  = 48;
   localparam int IVL_BITS   = 32;

   localparam logic [TIME_BITS-1:0] TIME_ONES    = '1;
   localparam logic [IVL_BITS-1:0]  WINDOW_RESET = 32'd3600000;

   // command codes
   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_CANCEL  = 3'd1;
   localparam logic [2:0] CMD_REFRESH = 3'd2;
   localparam logic [2:0] CMD_RESET   = 3'd3;
   localparam logic [2:0] CMD_EXPIRE  = 3'd4;
   localparam logic [2:0] CMD_QUERY   = 3'd5;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // datapath operations
   localparam logic [2:0] OP_NONE       = 3'd0;
   localparam logic [2:0] OP_LATCH      = 3'd1;
   localparam logic [2:0] OP_ADD_WR     = 3'd2;
   localparam logic [2:0] OP_CANCEL_WR  = 3'd3;
   localparam logic [2:0] OP_REFRESH_WR = 3'd4;
   localparam logic [2:0] OP_RST_START  = 3'd5;
   localparam logic [2:0] OP_RST_WR     = 3'd6;
   localparam logic [2:0] OP_EXP_PREV   = 3'd7;

   // scan modes
   localparam logic [1:0] SCAN_MIN_ACTIVE = 2'd0;
   localparam logic [1:0] SCAN_MIN_DUE    = 2'd1;
   localparam logic [1:0] SCAN_MARK       = 2'd2;

   // result kinds
   localparam logic [2:0] EMIT_ZERO   = 3'd0;
   localparam logic [2:0] EMIT_FULL   = 3'd1;
   localparam logic [2:0] EMIT_BAD    = 3'd2;
   localparam logic [2:0] EMIT_OK     = 3'd3;
   localparam logic [2:0] EMIT_NOTIFY = 3'd4;
   localparam logic [2:0] EMIT_EXP    = 3'd5;
   localparam logic [2:0] EMIT_QUERY  = 3'd6;

   typedef struct packed {
      logic [2:0] op;
      logic       scan_start;
      logic [1:0] scan_mode;
      logic       emit_en;
      logic [2:0] emit_kind;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       scan_busy;
      logic       full;
      logic       slot_ok;
      logic       no_change;
      logic       any_active;
      logic       any_due;
      logic       out_free;
   } stat_type;

   // saturating deadline sum
   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [IVL_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {{(TIME_BITS+1-IVL_BITS){1'b0}}, b};
      return s[TIME_BITS] ? TIME_ONES : s[TIME_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dtt_channels.sv =====
// channel interfaces of the timer table: request, response, csr write
`default_nettype none
interface dtt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [3:0]  slot;
   logic [31:0] period_ms;
   logic        periodic;
   logic        restart_now;
   logic [47:0] now_ms;
   modport source (output valid, cmd, slot, period_ms, periodic, restart_now, now_ms,
                   input ready);
   modport sink (input valid, cmd, slot, period_ms, periodic, restart_now, now_ms,
                 output ready);
endinterface

interface dtt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  timer_id;
   logic        expired;
   logic        wake_sched;
   logic [47:0] next_delay;
   logic        last;
   modport source (output valid, status, timer_id, expired, wake_sched, next_delay, last,
                   input ready);
   modport sink (input valid, status, timer_id, expired, wake_sched, next_delay, last,
                 output ready);
endinterface

interface dtt_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/dtt_datapath.sv =====
// timer table storage, min-deadline scanner and response register
`default_nettype none
`include "deadline_timer_table_top_macros.svh"
module dtt_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dtt_pkg::ctrl_type             ctrl,
   output dtt_pkg::stat_type                  stat,
   input  wire logic [2:0]                    req_cmd,
   input  wire logic [dtt_pkg::IDX_BITS-1:0]  req_slot,
   input  wire logic [dtt_pkg::IVL_BITS-1:0]  req_period_ms,
   input  wire logic                          req_periodic,
   input  wire logic                          req_restart_now,
   input  wire logic [dtt_pkg::TIME_BITS-1:0] req_now_ms,
   input  wire logic                          csr_valid,
   input  wire logic [dtt_pkg::IVL_BITS-1:0]  csr_data,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [dtt_pkg::IDX_BITS-1:0]       rsp_timer_id,
   output logic                               rsp_expired,
   output logic                               rsp_wake_sched,
   output logic [dtt_pkg::TIME_BITS-1:0]      rsp_next_delay,
   output logic                               rsp_last
);
   import dtt_pkg::*;

   // latched request
   logic [2:0]           cmd_ff;
   logic [IDX_BITS-1:0]  tgt_ff;
   logic [IVL_BITS-1:0]  period_ff;
   logic                 periodic_ff;
   logic                 restart_now_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 roll_ff;
   logic [TIME_BITS-1:0] start_ff;

   // table state
   logic [IVL_BITS-1:0]   window_ff;
   logic [TIME_BITS-1:0]  prev_ff;
   logic                  fn_ff;
   logic [NUM_TIMERS-1:0] active_ff;
   logic [NUM_TIMERS-1:0] rep_ff;
   logic [NUM_TIMERS-1:0] due_ff;
   logic [IVL_BITS-1:0]   ivl_ff [NUM_TIMERS];
   logic [TIME_BITS-1:0]  dl_ff [NUM_TIMERS];

   // scanner
   logic                 scan_run_ff;
   logic [IDX_BITS-1:0]  scan_idx_ff;
   logic [1:0]           scan_mode_ff;
   logic                 found_ff;
   logic [IDX_BITS-1:0]  best_ff;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic                 any_act_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic [IDX_BITS-1:0]  rsp_id_ff;
   logic                 rsp_exp_ff;
   logic                 rsp_front_ff;
   logic [TIME_BITS-1:0] rsp_delay_ff;
   logic                 rsp_last_ff;
   logic [1:0]           rsp_status_in;
   logic [IDX_BITS-1:0]  rsp_id_in;
   logic                 rsp_exp_in;
   logic                 rsp_front_in;
   logic [TIME_BITS-1:0] rsp_delay_in;
   logic                 rsp_last_in;

   logic [IDX_BITS-1:0]   free_idx;
   logic                  full;
   logic                  emit_exp;
   logic [IDX_BITS-1:0]   rd_idx;
   logic [TIME_BITS-1:0]  rd_dl;
   logic [IVL_BITS-1:0]   rd_ivl;
   logic                  rd_rep;
   logic                  rd_act;
   logic                  rd_due;
   logic [TIME_BITS-1:0]  sat_now_ivl;
   logic [TIME_BITS-1:0]  back_diff;
   logic                  roll_in;
   logic                  cand;
   logic                  take;
   logic                  notify;
   logic [NUM_TIMERS-1:0] due_rest;
   logic [TIME_BITS-1:0]  delay;
   logic                  out_free;

   // lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!active_ff[i]) free_idx = IDX_BITS'(i);
      end
   end
   assign full = &active_ff;

   // single table read port
   assign emit_exp = ctrl.emit_en && (ctrl.emit_kind == EMIT_EXP);
   assign rd_idx   = scan_run_ff ? scan_idx_ff : (emit_exp ? best_ff : tgt_ff);
   assign rd_dl    = dl_ff[rd_idx];
   assign rd_ivl   = ivl_ff[rd_idx];
   assign rd_rep   = rep_ff[rd_idx];
   assign rd_act   = active_ff[rd_idx];
   assign rd_due   = due_ff[rd_idx];
   assign sat_now_ivl = sat_add(now_ff, rd_ivl);

   // clock rollback test on the incoming time
   assign back_diff = prev_ff - req_now_ms;
   assign roll_in   = (prev_ff > req_now_ms) &&
                      (back_diff > {{(TIME_BITS-IVL_BITS){1'b0}}, window_ff});

   // scanner compare
   assign cand = (scan_mode_ff == SCAN_MIN_DUE) ? rd_due : rd_act;
   assign take = cand && (!found_ff || (rd_dl < best_dl_ff));

   assign notify   = found_ff && (best_ff == tgt_ff) && !fn_ff;
   assign due_rest = due_ff & ~(NUM_TIMERS'(1) << best_ff);
   assign delay    = !found_ff ? TIME_ONES :
                     ((now_ff >= best_dl_ff) ? '0 : best_dl_ff - now_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // status to controller
   always_comb begin
      stat.cmd        = cmd_ff;
      stat.scan_busy  = scan_run_ff;
      stat.full       = full;
      stat.slot_ok    = active_ff[tgt_ff];
      stat.no_change  = (period_ff == rd_ivl) && !restart_now_ff;
      stat.any_active = any_act_ff;
      stat.any_due    = |due_ff;
      stat.out_free   = out_free;
   end

   // request capture and target slot
   always_ff @(posedge clock) begin
      if (ctrl.op == OP_LATCH) begin
         cmd_ff         <= req_cmd;
         tgt_ff         <= req_slot;
         period_ff      <= req_period_ms;
         periodic_ff    <= req_periodic;
         restart_now_ff <= req_restart_now;
         now_ff         <= req_now_ms;
         roll_ff        <= roll_in;
      end else if (ctrl.op == OP_ADD_WR) begin
         tgt_ff <= free_idx;
      end
   end

   // table payload writes, one slot per cycle
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_ADD_WR: begin
            rep_ff[free_idx] <= periodic_ff;
            ivl_ff[free_idx] <= period_ff;
            dl_ff[free_idx]  <= sat_add(now_ff, period_ff);
         end
         OP_REFRESH_WR: dl_ff[tgt_ff] <= sat_now_ivl;
         OP_RST_START: start_ff <= restart_now_ff ? now_ff
                                   : rd_dl - {{(TIME_BITS-IVL_BITS){1'b0}}, rd_ivl};
         OP_RST_WR: begin
            ivl_ff[tgt_ff] <= period_ff;
            dl_ff[tgt_ff]  <= sat_add(start_ff, period_ff);
         end
         default: begin
            if (emit_exp && rd_rep) dl_ff[best_ff] <= sat_now_ivl;
         end
      endcase
   end

   // control state: active bits, notify flag, last time, window
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         fn_ff     <= 1'b0;
         prev_ff   <= '0;
         window_ff <= WINDOW_RESET;
      end else begin
         if (csr_valid) window_ff <= csr_data;
         if (ctrl.op == OP_ADD_WR) active_ff[free_idx] <= 1'b1;
         if (ctrl.op == OP_CANCEL_WR) active_ff[tgt_ff] <= 1'b0;
         if (emit_exp && !rd_rep) active_ff[best_ff] <= 1'b0;
         if (ctrl.op == OP_EXP_PREV) prev_ff <= now_ff;
         if (ctrl.emit_en && ctrl.emit_kind == EMIT_NOTIFY && notify) fn_ff <= 1'b1;
         if (ctrl.emit_en && ctrl.emit_kind == EMIT_QUERY) fn_ff <= 1'b0;
      end
   end

   // sequential scan over all slots, one per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         due_ff      <= '0;
      end else if (ctrl.scan_start) begin
         scan_run_ff <= 1'b1;
      end else if (scan_run_ff) begin
         if (scan_idx_ff == IDX_BITS'(NUM_TIMERS - 1)) scan_run_ff <= 1'b0;
         if (scan_mode_ff == SCAN_MARK)
            due_ff[scan_idx_ff] <= rd_act && (roll_ff || rd_dl <= now_ff);
      end else if (emit_exp) begin
         due_ff <= due_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_start) begin
         scan_idx_ff  <= '0;
         scan_mode_ff <= ctrl.scan_mode;
         found_ff     <= 1'b0;
         any_act_ff   <= 1'b0;
      end else if (scan_run_ff) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
         any_act_ff  <= any_act_ff | rd_act;
         if (take && scan_mode_ff != SCAN_MARK) begin
            found_ff   <= 1'b1;
            best_ff    <= scan_idx_ff;
            best_dl_ff <= rd_dl;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (ctrl.emit_en) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   // next result fields by kind
   always_comb begin
      rsp_status_in = ST_OK;
      rsp_id_in     = '0;
      rsp_exp_in    = 1'b0;
      rsp_front_in  = 1'b0;
      rsp_delay_in  = '0;
      rsp_last_in   = 1'b1;
      unique case (ctrl.emit_kind)
         EMIT_FULL: rsp_status_in = ST_FULL;
         EMIT_BAD: begin
            rsp_status_in = ST_INACTIVE;
            rsp_id_in     = tgt_ff;
         end
         EMIT_OK: rsp_id_in = tgt_ff;
         EMIT_NOTIFY: begin
            rsp_id_in    = tgt_ff;
            rsp_front_in = notify;
         end
         EMIT_EXP: begin
            rsp_id_in   = best_ff;
            rsp_exp_in  = 1'b1;
            rsp_last_in = ~|due_rest;
         end
         EMIT_QUERY: rsp_delay_in = delay;
         default: rsp_last_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_exp_ff    <= rsp_exp_in;
         rsp_front_ff  <= rsp_front_in;
         rsp_delay_ff  <= rsp_delay_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_timer_id   = rsp_id_ff;
   assign rsp_expired    = rsp_exp_ff;
   assign rsp_wake_sched = rsp_front_ff;
   assign rsp_next_delay = rsp_delay_ff;
   assign rsp_last       = rsp_last_ff;

   `DTT_ASSERT(a_no_emit_while_scan, scan_run_ff |-> !ctrl.emit_en, "result during scan")
   `DTT_ASSERT(a_add_sets_active, $past(ctrl.op == OP_ADD_WR) |-> active_ff[tgt_ff],
               "added slot not active")
   `DTT_ASSERT(a_exp_slot_due, emit_exp |-> (due_ff[best_ff] && found_ff),
               "expired slot not due")
   `DTT_ASSERT(a_query_clears_front, (ctrl.emit_en && ctrl.emit_kind == EMIT_QUERY) |=> !fn_ff,
               "query left front flag set")
   `DTT_ASSERT_ALWAYS(a_reset_idle, reset |=> (!scan_run_ff && !rsp_valid_ff),
                      "reset left scan or response busy")
endmodule
`default_nettype wire

// ===== rtl/dtt_ctrl.sv =====
// command sequencer of the timer table
`default_nettype none
module dtt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire dtt_pkg::stat_type stat,
   output dtt_pkg::ctrl_type      ctrl
);
   import dtt_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISP     = 4'd1;
   localparam logic [3:0] S_RST_WR   = 4'd2;
   localparam logic [3:0] S_NOTE     = 4'd3;
   localparam logic [3:0] S_MARK     = 4'd4;
   localparam logic [3:0] S_SEL      = 4'd5;
   localparam logic [3:0] S_EXP_EMIT = 4'd6;
   localparam logic [3:0] S_EXP_CHK  = 4'd7;
   localparam logic [3:0] S_QUERY    = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [2:0] kind_ff, kind_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.op  = OP_LATCH;
               state_in = S_DISP;
            end
         end
         // decode the latched command
         S_DISP: begin
            state_in = S_EMIT;
            unique case (stat.cmd)
               CMD_ADD: begin
                  if (stat.full) kind_in = EMIT_FULL;
                  else begin
                     ctrl.op         = OP_ADD_WR;
                     ctrl.scan_start = 1'b1;
                     ctrl.scan_mode  = SCAN_MIN_ACTIVE;
                     state_in        = S_NOTE;
                  end
               end
               CMD_CANCEL, CMD_REFRESH: begin
                  if (stat.slot_ok) begin
                     ctrl.op = (stat.cmd == CMD_CANCEL) ? OP_CANCEL_WR : OP_REFRESH_WR;
                     kind_in = EMIT_OK;
                  end else kind_in = EMIT_BAD;
               end
               CMD_RESET: begin
                  if (!stat.slot_ok) kind_in = EMIT_BAD;
                  else if (stat.no_change) kind_in = EMIT_OK;
                  else begin
                     ctrl.op  = OP_RST_START;
                     state_in = S_RST_WR;
                  end
               end
               CMD_EXPIRE: begin
                  ctrl.scan_start = 1'b1;
                  ctrl.scan_mode  = SCAN_MARK;
                  state_in        = S_MARK;
               end
               CMD_QUERY: begin
                  ctrl.scan_start = 1'b1;
                  ctrl.scan_mode  = SCAN_MIN_ACTIVE;
                  state_in        = S_QUERY;
               end
               default: kind_in = EMIT_ZERO;
            endcase
         end
         S_RST_WR: begin
            ctrl.op         = OP_RST_WR;
            ctrl.scan_start = 1'b1;
            ctrl.scan_mode  = SCAN_MIN_ACTIVE;
            state_in        = S_NOTE;
         end
         S_NOTE: begin
            if (!stat.scan_busy) begin
               kind_in  = EMIT_NOTIFY;
               state_in = S_EMIT;
            end
         end
         // due bits marked: decide whether anything expires
         S_MARK: begin
            if (!stat.scan_busy) begin
               if (!stat.any_active) begin
                  kind_in  = EMIT_ZERO;
                  state_in = S_EMIT;
               end else begin
                  ctrl.op = OP_EXP_PREV;
                  if (stat.any_due) begin
                     ctrl.scan_start = 1'b1;
                     ctrl.scan_mode  = SCAN_MIN_DUE;
                     state_in        = S_SEL;
                  end else begin
                     kind_in  = EMIT_ZERO;
                     state_in = S_EMIT;
                  end
               end
            end
         end
         S_SEL: begin
            if (!stat.scan_busy) state_in = S_EXP_EMIT;
         end
         S_EXP_EMIT: begin
            if (stat.out_free) begin
               ctrl.emit_en   = 1'b1;
               ctrl.emit_kind = EMIT_EXP;
               state_in       = S_EXP_CHK;
            end
         end
         S_EXP_CHK: begin
            if (stat.any_due) begin
               ctrl.scan_start = 1'b1;
               ctrl.scan_mode  = SCAN_MIN_DUE;
               state_in        = S_SEL;
            end else state_in = S_IDLE;
         end
         S_QUERY: begin
            if (!stat.scan_busy) begin
               kind_in  = EMIT_QUERY;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               ctrl.emit_en   = 1'b1;
               ctrl.emit_kind = kind_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end
endmodule
`default_nettype wire

// ===== rtl/deadline_timer_table_top.sv =====
// top level of the deadline timer table
`default_nettype none
// Table of sixteen one-shot or periodic millisecond timers driven by commands
// (add, cancel, refresh, reset, expire, query). One command is taken at a time;
// req is ready only when the previous command has finished. Add and reset, when
// they write a slot, and query wait on a one-slot-per-cycle scan for the earliest
// deadline; cancel, refresh and unknown codes do not scan. Expire runs a marking
// scan of all slots, then one selection scan per expired timer, emitted in
// deadline order. Results sit in an output register, so a stalled rsp only holds
// the block at the next result. The csr write port is always ready and should be
// used while idle.
module deadline_timer_table_top (
   input wire logic clock,
   input wire logic reset,
   dtt_req_if.sink   req_ch,
   dtt_rsp_if.source rsp_ch,
   dtt_csr_if.sink   csr_ch
);
   import dtt_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   assign csr_ch.ready = 1'b1;

   dtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   dtt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_cmd         (req_ch.cmd),
      .req_slot        (req_ch.slot),
      .req_period_ms   (req_ch.period_ms),
      .req_periodic    (req_ch.periodic),
      .req_restart_now (req_ch.restart_now),
      .req_now_ms      (req_ch.now_ms),
      .csr_valid       (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_status      (rsp_ch.status),
      .rsp_timer_id    (rsp_ch.timer_id),
      .rsp_expired     (rsp_ch.expired),
      .rsp_wake_sched  (rsp_ch.wake_sched),
      .rsp_next_delay  (rsp_ch.next_delay),
      .rsp_last        (rsp_ch.last)
   );
endmodule
`default_nettype wire
